FILE: hw/rtl/mfvn_pkg.sv
// Shared types, codes and default sizes for the mesh normal core.
`default_nettype none
package mfvn_pkg;

  localparam int VERTEX_CAPACITY_DEF = 4096;
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int ACCUM_WIDTH_DEF     = 24;

  // Shared multiplier operand width and the fixed normalize window.
  localparam int MUL_W  = 25;
  localparam int SQ_W   = 24;
  localparam int SUM_W  = 50;
  localparam int RAD_W  = 62;
  localparam int ROOT_W = 31;
  localparam int REM_W  = 34;
  localparam int NUM_W  = 45;
  localparam int QUO_W  = 16;
  localparam logic [QUO_W-1:0] UNIT_Q = 16'd16384;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FACE  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_POS_RD,
    ST_DIFF,
    ST_CROSS,
    ST_ACC_LD,
    ST_MAG,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [11:0]        vertex_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [11:0]        corner_a;
    logic [11:0]        corner_b;
    logic [11:0]        corner_c;
  } mfvn_in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
  } mfvn_out_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mfvn_ram.sv
// Generic simple dual-port RAM with a registered read port.
`default_nettype none
module mfvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: hw/rtl/mesh_face_vertex_normals_core.sv
// Top level of the mesh face and vertex normal core.
//
//   channel | direction | handshake             | payload
//   in_     | request   | in_valid / in_stall   | mfvn_in_t  (operation, index, coords, corners)
//   out_    | response  | out_valid / out_stall | mfvn_out_t (normal x/y/z, degenerate)
//
// A write-vertex or clear request is answered on acceptance, straight from idle. Add-face
// and read requests spend most of their time in the square root (one result bit a cycle)
// and the three divisions (a load step, then a 16-bit quotient formed bit by bit) that
// share one subtractor. The cross product on a single 25x25 multiplier adds further
// time to a face.
// After reset and after each clear request the accumulator memory is swept to zero,
// one entry per cycle across all VERTEX_CAPACITY entries, while no request is taken.
// A finished response waits in the output register; a new request is taken in idle as long
// as that register is empty or being emptied in the same cycle.
`default_nettype none
module mesh_face_vertex_normals_core #(
  parameter int VERTEX_CAPACITY = mfvn_pkg::VERTEX_CAPACITY_DEF,
  parameter int COORD_WIDTH     = mfvn_pkg::COORD_WIDTH_DEF,
  parameter int ACCUM_WIDTH     = mfvn_pkg::ACCUM_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mfvn_pkg::mfvn_in_t  in_req,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mfvn_pkg::mfvn_out_t      out_rsp
);
  import mfvn_pkg::*;

  localparam int AW    = $clog2(VERTEX_CAPACITY);
  localparam int CW    = COORD_WIDTH;
  localparam int ACW   = ACCUM_WIDTH;
  localparam int XW    = 2 * CW + 3;
  // Magnitude width covers both a cross product and an accumulator.
  localparam int MW0   = (XW > ACW) ? XW : ACW;
  localparam int MW    = (MW0 > 25) ? MW0 : 25;
  localparam int POS_W = 3 * CW;
  localparam int ACC_W = 3 * ACW + 1;
  localparam logic signed [ACW:0] SAT_HI =
    (ACW+1)'((64'sd1 <<< (ACW - 1)) - 64'sd1);
  localparam logic signed [ACW:0] SAT_LO = -SAT_HI - (ACW+1)'(1);
  localparam logic [AW-1:0] LAST_IDX = AW'(VERTEX_CAPACITY - 1);

  // Control and datapath registers.
  state_t                 state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [4:0]             cnt_r, cnt_nxt;
  logic [1:0]             comp_r, comp_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [AW-1:0]          k_r [3];
  logic [AW-1:0]          k_nxt [3];
  logic signed [CW-1:0]   p_r [3][3];
  logic signed [CW-1:0]   p_nxt [3][3];
  logic signed [CW:0]     u_r [3];
  logic signed [CW:0]     u_nxt [3];
  logic signed [CW:0]     v_r [3];
  logic signed [CW:0]     v_nxt [3];
  logic signed [MW:0]     cr_r [3];
  logic signed [MW:0]     cr_nxt [3];
  logic [MW-1:0]          mag_r [3];
  logic [MW-1:0]          mag_nxt [3];
  logic                   neg_r [3];
  logic                   neg_nxt [3];
  logic signed [15:0]     n_r [3];
  logic signed [15:0]     n_nxt [3];
  logic                   deg_r, deg_nxt;
  logic signed [2*MUL_W-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [RAD_W-1:0]       rad_r, rad_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [ROOT_W-1:0]      root_r, root_nxt;
  logic [QUO_W-1:0]       dq_r, dq_nxt;
  logic [QUO_W-1:0]       dlow_r, dlow_nxt;
  logic                   out_valid_r, out_valid_nxt;
  mfvn_out_t              out_rsp_r, out_rsp_nxt;

  // Memory ports.
  logic                   pos_we;
  logic [AW-1:0]          pos_wa, pos_ra;
  logic [POS_W-1:0]       pos_wd, pos_rd;
  logic                   acc_we;
  logic [AW-1:0]          acc_wa, acc_ra;
  logic [ACC_W-1:0]       acc_wd, acc_rd;

  // Combinational helpers.
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic                    accept;
  logic                    idx_ok, face_ok;
  logic [MW-1:0]           mg [3];
  logic [MW-1:0]           mx;
  logic [4:0]              j;
  logic [1:0]              ci;
  logic [REM_W-1:0]        r2, trial;
  logic [NUM_W-1:0]        num;
  logic [REM_W-1:0]        dt;
  logic [QUO_W-1:0]        qf;
  logic signed [ACW:0]     s3 [3];
  logic signed [ACW-1:0]   a_old [3];
  logic [ACC_W-2:0]        acc_sum;

  mfvn_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_CAPACITY)) u_pos_ram (
    .clk     (clk),
    .wr_en   (pos_we),
    .wr_addr (pos_wa),
    .wr_data (pos_wd),
    .rd_addr (pos_ra),
    .rd_data (pos_rd)
  );

  mfvn_ram #(.WIDTH(ACC_W), .DEPTH(VERTEX_CAPACITY)) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_we),
    .wr_addr (acc_wa),
    .wr_data (acc_wd),
    .rd_addr (acc_ra),
    .rd_data (acc_rd)
  );

  // Requests are taken only in idle and only when the response register is free.
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // One shared multiplier serves the cross product and the sum of squares.
  assign prod_nxt  = mul_a * mul_b;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    comp_nxt      = comp_r;
    clr_nxt       = clr_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    cr_nxt        = cr_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    deg_nxt       = deg_r;
    sum_nxt       = sum_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    dq_nxt        = dq_r;
    dlow_nxt      = dlow_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    pos_we        = 1'b0;
    pos_wa        = '0;
    pos_wd        = '0;
    pos_ra        = '0;
    acc_we        = 1'b0;
    acc_wa        = '0;
    acc_wd        = '0;
    acc_ra        = '0;
    mul_a         = '0;
    mul_b         = '0;
    idx_ok        = 32'(in_req.vertex_index) < 32'(VERTEX_CAPACITY);
    face_ok       = (32'(in_req.corner_a) < 32'(VERTEX_CAPACITY)) &&
                    (32'(in_req.corner_b) < 32'(VERTEX_CAPACITY)) &&
                    (32'(in_req.corner_c) < 32'(VERTEX_CAPACITY));
    j             = cnt_r - 5'd1;
    ci            = j[2:1];
    r2            = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial         = {1'b0, root_r, 2'b01};
    num           = {1'b0, mag_r[comp_r][SQ_W-1:0], 20'b0} + NUM_W'(root_r >> 1);
    dt            = {rem_r[REM_W-2:0], dlow_r[QUO_W-1]};
    qf            = '0;
    acc_sum       = '0;
    for (int i = 0; i < 3; i++) begin
      mg[i]    = cr_r[i][MW] ? MW'(-cr_r[i]) : MW'(cr_r[i]);
      a_old[i] = $signed(acc_rd[i*ACW +: ACW]);
      s3[i]    = (ACW+1)'(a_old[i]) + (ACW+1)'(n_r[i]);
    end
    mx = mg[0];
    if (mg[1] > mx) mx = mg[1];
    if (mg[2] > mx) mx = mg[2];

    unique case (state_r)
      ST_CLR: begin
        acc_we  = 1'b1;
        acc_wa  = clr_r;
        acc_wd  = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_req.operation;
          k_nxt[0] = AW'(in_req.corner_a);
          k_nxt[1] = AW'(in_req.corner_b);
          k_nxt[2] = AW'(in_req.corner_c);
          cnt_nxt  = '0;
          unique case (in_req.operation)
            OP_WRITE: begin
              pos_we        = idx_ok;
              pos_wa        = AW'(in_req.vertex_index);
              pos_wd        = {CW'($unsigned(in_req.coord_z)),
                               CW'($unsigned(in_req.coord_y)),
                               CW'($unsigned(in_req.coord_x))};
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '0;
            end
            OP_FACE: begin
              pos_ra = AW'(in_req.corner_a);
              if (face_ok) begin
                state_nxt = ST_POS_RD;
              end else begin
                out_valid_nxt          = 1'b1;
                out_rsp_nxt            = '0;
                out_rsp_nxt.degenerate = 1'b1;
              end
            end
            OP_READ: begin
              acc_ra = AW'(in_req.vertex_index);
              if (idx_ok) begin
                state_nxt = ST_ACC_LD;
              end else begin
                out_valid_nxt          = 1'b1;
                out_rsp_nxt            = '0;
                out_rsp_nxt.degenerate = 1'b1;
              end
            end
            OP_CLEAR: begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '0;
              clr_nxt       = '0;
              state_nxt     = ST_CLR;
            end
          endcase
        end
      end

      // Corner positions arrive one per cycle behind their addresses.
      ST_POS_RD: begin
        for (int i = 0; i < 3; i++) begin
          p_nxt[cnt_r[1:0]][i] = $signed(pos_rd[i*CW +: CW]);
        end
        if (cnt_r == 5'd0) begin
          pos_ra = k_r[1];
        end else if (cnt_r == 5'd1) begin
          pos_ra = k_r[2];
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd2) begin
          state_nxt = ST_DIFF;
        end
      end

      ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          u_nxt[i]  = (CW+1)'(p_r[1][i]) - (CW+1)'(p_r[0][i]);
          v_nxt[i]  = (CW+1)'(p_r[2][i]) - (CW+1)'(p_r[0][i]);
          cr_nxt[i] = '0;
        end
        cnt_nxt   = '0;
        state_nxt = ST_CROSS;
      end

      // Six products, each added or subtracted in the cycle after it is formed.
      ST_CROSS: begin
        unique case (cnt_r)
          5'd0: begin mul_a = MUL_W'(u_r[1]); mul_b = MUL_W'(v_r[2]); end
          5'd1: begin mul_a = MUL_W'(u_r[2]); mul_b = MUL_W'(v_r[1]); end
          5'd2: begin mul_a = MUL_W'(u_r[2]); mul_b = MUL_W'(v_r[0]); end
          5'd3: begin mul_a = MUL_W'(u_r[0]); mul_b = MUL_W'(v_r[2]); end
          5'd4: begin mul_a = MUL_W'(u_r[0]); mul_b = MUL_W'(v_r[1]); end
          5'd5: begin mul_a = MUL_W'(u_r[1]); mul_b = MUL_W'(v_r[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt_r != 5'd0) begin
          if (j[0]) begin
            cr_nxt[ci] = cr_r[ci] - (MW+1)'(prod_r);
          end else begin
            cr_nxt[ci] = cr_r[ci] + (MW+1)'(prod_r);
          end
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd6) begin
          state_nxt = ST_MAG;
        end
      end

      ST_ACC_LD: begin
        if (!acc_rd[ACC_W-1]) begin
          for (int i = 0; i < 3; i++) begin
            n_nxt[i] = '0;
          end
          deg_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          for (int i = 0; i < 3; i++) begin
            cr_nxt[i] = (MW+1)'(a_old[i]);
          end
          state_nxt = ST_MAG;
        end
      end

      ST_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mag_nxt[i] = mg[i];
          neg_nxt[i] = cr_r[i][MW];
        end
        cnt_nxt = '0;
        if (mx == '0) begin
          for (int i = 0; i < 3; i++) begin
            n_nxt[i] = '0;
          end
          deg_nxt   = 1'b1;
          state_nxt = (op_r == OP_FACE) ? ST_ACC_RD : ST_DONE;
        end else begin
          deg_nxt   = 1'b0;
          state_nxt = ST_SHIFT;
        end
      end

      // Bring the largest magnitude into [2^23, 2^24), eight or one bit a cycle.
      ST_SHIFT: begin
        mx = mag_r[0];
        if (mag_r[1] > mx) mx = mag_r[1];
        if (mag_r[2] > mx) mx = mag_r[2];
        for (int i = 0; i < 3; i++) begin
          if ((mx >> 32) != '0) begin
            mag_nxt[i] = mag_r[i] >> 8;
          end else if ((mx >> 24) != '0) begin
            mag_nxt[i] = mag_r[i] >> 1;
          end else if ((mx >> 15) == '0) begin
            mag_nxt[i] = mag_r[i] << 8;
          end else if ((mx >> 23) == '0) begin
            mag_nxt[i] = mag_r[i] << 1;
          end
        end
        if (((mx >> 24) == '0) && ((mx >> 23) != '0)) begin
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SQ;
        end
      end

      ST_SQ: begin
        if (cnt_r != 5'd3) begin
          mul_a = $signed({1'b0, mag_r[cnt_r[1:0]][SQ_W-1:0]});
          mul_b = $signed({1'b0, mag_r[cnt_r[1:0]][SQ_W-1:0]});
        end
        if (cnt_r != 5'd0) begin
          sum_nxt = sum_r + SUM_W'($unsigned(prod_r));
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd3) begin
          rad_nxt   = {sum_nxt, 12'b0};
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end
      end

      // Digit-by-digit square root, one result bit a cycle.
      ST_SQRT: begin
        rad_nxt = rad_r << 2;
        if (r2 >= trial) begin
          rem_nxt  = r2 - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = r2;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          cnt_nxt   = '0;
          comp_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end

      // Rounded division of each magnitude by the length, one quotient bit a cycle.
      ST_DIV: begin
        if (cnt_r == 5'd0) begin
          rem_nxt  = REM_W'(num >> QUO_W);
          dlow_nxt = num[QUO_W-1:0];
          dq_nxt   = '0;
          cnt_nxt  = 5'd1;
        end else begin
          dlow_nxt = dlow_r << 1;
          if (dt >= {3'b0, root_r}) begin
            rem_nxt = dt - {3'b0, root_r};
            qf      = {dq_r[QUO_W-2:0], 1'b1};
          end else begin
            rem_nxt = dt;
            qf      = {dq_r[QUO_W-2:0], 1'b0};
          end
          dq_nxt  = qf;
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == 5'd16) begin
            if (qf > UNIT_Q) qf = UNIT_Q;
            n_nxt[comp_r] = neg_r[comp_r] ? -$signed(qf) : $signed(qf);
            cnt_nxt       = '0;
            comp_nxt      = comp_r + 2'd1;
            if (comp_r == 2'd2) begin
              state_nxt = (op_r == OP_FACE) ? ST_ACC_RD : ST_DONE;
            end
          end
        end
      end

      // Corners are updated strictly one after another, so a repeated corner
      // sees its own earlier write.
      ST_ACC_RD: begin
        acc_ra    = k_r[cnt_r[1:0]];
        state_nxt = ST_ACC_WR;
      end

      ST_ACC_WR: begin
        for (int i = 0; i < 3; i++) begin
          if (s3[i] > SAT_HI) begin
            acc_sum[i*ACW +: ACW] = SAT_HI[ACW-1:0];
          end else if (s3[i] < SAT_LO) begin
            acc_sum[i*ACW +: ACW] = SAT_LO[ACW-1:0];
          end else begin
            acc_sum[i*ACW +: ACW] = s3[i][ACW-1:0];
          end
        end
        acc_we  = 1'b1;
        acc_wa  = k_r[cnt_r[1:0]];
        acc_wd  = {1'b1, acc_sum};
        cnt_nxt = cnt_r + 5'd1;
        state_nxt = (cnt_r == 5'd2) ? ST_DONE : ST_ACC_RD;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_rsp_nxt.normal_x   = n_r[0];
          out_rsp_nxt.normal_y   = n_r[1];
          out_rsp_nxt.normal_z   = n_r[2];
          out_rsp_nxt.degenerate = deg_r;
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    k_r       <= k_nxt;
    p_r       <= p_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    cr_r      <= cr_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    n_r       <= n_nxt;
    deg_r     <= deg_nxt;
    prod_r    <= prod_nxt;
    sum_r     <= sum_nxt;
    rad_r     <= rad_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    dq_r      <= dq_nxt;
    dlow_r    <= dlow_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule
`default_nettype wire

FILE: tb/sv/mfvn_checker.sv
// Scoreboard for the mesh normal core: predicts every response and compares it.
`timescale 1ns / 100ps
module mfvn_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  mfvn_pkg::mfvn_in_t  in_req,
  input  logic                out_valid,
  input  logic                out_stall,
  input  mfvn_pkg::mfvn_out_t out_rsp,
  output int                  mismatch_count,
  output int                  normals_pending
);
  import mfvn_pkg::*;

  localparam int VCAP    = 4096;
  localparam int ACC_MAX = 8388607;
  localparam int ACC_MIN = -8388608;

  logic signed [15:0] vertex_pos_x [VCAP];
  logic signed [15:0] vertex_pos_y [VCAP];
  logic signed [15:0] vertex_pos_z [VCAP];
  int                 normal_sum_x [VCAP];
  int                 normal_sum_y [VCAP];
  int                 normal_sum_z [VCAP];
  bit                 vertex_touched [VCAP];
  mfvn_out_t          normals_due [$];
  int                 fail_total = 0;
  int                 due_total = 0;

  assign mismatch_count  = fail_total;
  assign normals_pending = due_total;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned rt, b;
    rt = 0;
    b  = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= rt + b) begin
        v  = v - (rt + b);
        rt = (rt >> 1) + b;
      end else begin
        rt = rt >> 1;
      end
      b >>= 2;
    end
    return rt;
  endfunction

  // Scale to a common window, then divide each magnitude by the length with rounding.
  function automatic mfvn_out_t unit_vec(longint cx, longint cy, longint cz);
    longint          c [3];
    longint unsigned m [3];
    longint unsigned mx, s, len, q;
    logic [15:0]     comp [3];
    mfvn_out_t       r;
    c  = '{cx, cy, cz};
    mx = 0;
    r  = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    while (mx >= (64'd1 << 24)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 23)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    s = 0;
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    len = int_root(s << 12);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 20) + len / 2) / len;
      if (q > 16384) q = 16384;
      comp[i] = q[15:0];
      if (c[i] < 0) comp[i] = -comp[i];
    end
    r.normal_x = comp[0];
    r.normal_y = comp[1];
    r.normal_z = comp[2];
    return r;
  endfunction

  function automatic int sat_sum(int acc, int add);
    longint t;
    t = longint'(acc) + longint'(add);
    if (t > ACC_MAX) t = ACC_MAX;
    if (t < ACC_MIN) t = ACC_MIN;
    return int'(t);
  endfunction

  function automatic mfvn_out_t predict_normal(mfvn_in_t r);
    mfvn_out_t res;
    longint    ux, uy, uz, vx, vy, vz;
    int        k [3];
    res = '0;
    case (r.operation)
      OP_WRITE: begin
        vertex_pos_x[r.vertex_index] = r.coord_x;
        vertex_pos_y[r.vertex_index] = r.coord_y;
        vertex_pos_z[r.vertex_index] = r.coord_z;
      end
      OP_FACE: begin
        k  = '{r.corner_a, r.corner_b, r.corner_c};
        ux = longint'(vertex_pos_x[k[1]]) - longint'(vertex_pos_x[k[0]]);
        uy = longint'(vertex_pos_y[k[1]]) - longint'(vertex_pos_y[k[0]]);
        uz = longint'(vertex_pos_z[k[1]]) - longint'(vertex_pos_z[k[0]]);
        vx = longint'(vertex_pos_x[k[2]]) - longint'(vertex_pos_x[k[0]]);
        vy = longint'(vertex_pos_y[k[2]]) - longint'(vertex_pos_y[k[0]]);
        vz = longint'(vertex_pos_z[k[2]]) - longint'(vertex_pos_z[k[0]]);
        res = unit_vec(uy * vz - uz * vy, uz * vx - ux * vz, ux * vy - uy * vx);
        // Repeated corners accumulate once per appearance.
        for (int i = 0; i < 3; i++) begin
          normal_sum_x[k[i]]   = sat_sum(normal_sum_x[k[i]], res.normal_x);
          normal_sum_y[k[i]]   = sat_sum(normal_sum_y[k[i]], res.normal_y);
          normal_sum_z[k[i]]   = sat_sum(normal_sum_z[k[i]], res.normal_z);
          vertex_touched[k[i]] = 1'b1;
        end
      end
      OP_READ: begin
        if (!vertex_touched[r.vertex_index]) res.degenerate = 1'b1;
        else res = unit_vec(normal_sum_x[r.vertex_index], normal_sum_y[r.vertex_index],
                            normal_sum_z[r.vertex_index]);
      end
      default: begin
        foreach (normal_sum_x[i]) begin
          normal_sum_x[i]   = 0;
          normal_sum_y[i]   = 0;
          normal_sum_z[i]   = 0;
          vertex_touched[i] = 1'b0;
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    mfvn_out_t want;
    if (!rst_n) begin
      normals_due.delete();
      foreach (normal_sum_x[i]) begin
        normal_sum_x[i]   = 0;
        normal_sum_y[i]   = 0;
        normal_sum_z[i]   = 0;
        vertex_touched[i] = 1'b0;
        vertex_pos_x[i]   = '0;
        vertex_pos_y[i]   = '0;
        vertex_pos_z[i]   = '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        if (normals_due.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: response with nothing outstanding: %p", $realtime, out_rsp);
        end else begin
          want = normals_due.pop_front();
          if (want.normal_x !== out_rsp.normal_x || want.normal_y !== out_rsp.normal_y ||
              want.normal_z !== out_rsp.normal_z || want.degenerate !== out_rsp.degenerate) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t: mismatch expected (%0d,%0d,%0d deg %0b) got (%0d,%0d,%0d deg %0b)",
                       $realtime, want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                       out_rsp.normal_x, out_rsp.normal_y, out_rsp.normal_z,
                       out_rsp.degenerate);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want        = predict_normal(in_req);
        normals_due = {normals_due, want};
      end
    end
    due_total <= normals_due.size();
  end

endmodule

FILE: tb/sv/tb_mesh_face_vertex_normals_core.sv
// Testbench top for the mesh normal core: stimulus, handshake pressure and verdict.
`timescale 1ns / 100ps
module tb_mesh_face_vertex_normals_core;
  import mfvn_pkg::*;

  // A clear is followed by a sweep of all 4096 accumulator entries and a face runs
  // through a square root and three divisions, so a quiet stretch far beyond both means the core has hung.
  localparam int QUIET_LIMIT = 40000;
  localparam int BURST_FACES = 530;
  localparam int PHASE_REQS  = 65;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  mfvn_in_t  in_req = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  mfvn_out_t out_rsp;
  int        mismatch_count;
  int        normals_pending;

  int        send_idle = 0;
  int        recv_idle = 0;
  int        quiet_cycles = 0;
  int        op_count [4] = '{0, 0, 0, 0};
  bit        written [4096];
  int        written_list [$];

  always #6 clk = ~clk;

  mesh_face_vertex_normals_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  mfvn_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req          (in_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rsp         (out_rsp),
    .mismatch_count  (mismatch_count),
    .normals_pending (normals_pending)
  );

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // The watchdog resets whenever either channel completes a handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Fields that the operation does not use carry random bits, so every bit toggles.
  function automatic mfvn_in_t noisy_req(op_t op);
    logic [127:0] raw;
    mfvn_in_t     r;
    raw = {$urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(mfvn_in_t)-1:0];
    r.operation = op;
    return r;
  endfunction

  // Sends one request, with a random gap in front of it, and returns on acceptance.
  task automatic send(mfvn_in_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    op_count[r.operation]++;
  endtask

  task automatic put_vertex(int idx, int x, int y, int z);
    mfvn_in_t r;
    r = noisy_req(OP_WRITE);
    r.vertex_index = 12'(idx);
    r.coord_x = 16'(x);
    r.coord_y = 16'(y);
    r.coord_z = 16'(z);
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_list = {written_list, idx};
    end
    send(r);
  endtask

  task automatic put_face(int a, int b, int c);
    mfvn_in_t r;
    r = noisy_req(OP_FACE);
    r.corner_a = 12'(a);
    r.corner_b = 12'(b);
    r.corner_c = 12'(c);
    send(r);
  endtask

  task automatic put_read(int idx);
    mfvn_in_t r;
    r = noisy_req(OP_READ);
    r.vertex_index = 12'(idx);
    send(r);
  endtask

  // Holds the sender off until every outstanding response has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (normals_pending != 0) @(posedge clk);
  endtask

  // Mostly full-range coordinates, some small ones and some at the rails.
  function automatic int rand_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      case ($urandom_range(3))
        0: return -32768;
        1: return 32767;
        2: return 0;
        default: return -1;
      endcase
    end
    if (sel <= 3) return int'($urandom_range(4095)) - 2048;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  // One random request. Faces use only written vertices; some repeat a corner
  // to force degenerate triangles.
  task automatic rand_request();
    int sel, a, b, c, idx;
    sel = $urandom_range(99);
    if (sel < 1) begin
      send(noisy_req(OP_CLEAR));
    end else if (sel < 28) begin
      idx = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(47);
      put_vertex(idx, rand_coord(), rand_coord(), rand_coord());
    end else if (sel < 68) begin
      a = pick_written();
      b = pick_written();
      c = pick_written();
      case ($urandom_range(9))
        0: b = a;
        1: c = b;
        default: ;
      endcase
      put_face(a, b, c);
    end else begin
      put_read(($urandom_range(3) == 0) ? $urandom_range(4095) : pick_written());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: a unit triangle, its mirror, rail coordinates, degenerate
    // faces, unused vertices, the top index, and a clear.
    send_idle = 0;
    recv_idle = 0;
    put_vertex(0, 0, 0, 0);
    put_vertex(1, 4096, 0, 0);
    put_vertex(2, 0, 4096, 0);
    put_vertex(3, 32767, -32768, 32767);
    put_vertex(4095, -32768, 32767, -32768);
    put_face(0, 1, 2);
    put_read(0);
    put_face(0, 2, 1);     // mirrored face cancels the sum at its corners
    put_read(0);
    put_face(0, 0, 1);     // repeated corner: zero normal, corners still marked
    put_read(1);
    put_read(5);           // never touched by a face
    put_face(3, 4095, 0);
    put_face(4095, 3, 2);
    put_read(4095);
    put_read(3);
    send(noisy_req(OP_CLEAR));
    put_read(3);
    put_face(3, 3, 3);
    put_read(3);

    // Busy sender, slow receiver.
    send_idle = 18;
    recv_idle = 80;
    repeat (PHASE_REQS) rand_request();
    drain();

    // Slow sender, busy receiver.
    send_idle = 80;
    recv_idle = 18;
    repeat (PHASE_REQS) rand_request();

    // Back to back, including enough faces on one corner to pin the z sum at
    // its positive rail, then an x face and mirrored faces on top of it.
    send_idle = 0;
    recv_idle = 0;
    repeat (PHASE_REQS) rand_request();
    send(noisy_req(OP_CLEAR));
    put_vertex(4000, 0, 0, 0);
    put_vertex(4001, 4096, 0, 0);
    put_vertex(4002, 0, 4096, 0);
    put_vertex(4003, 0, 0, 4096);
    repeat (BURST_FACES) put_face(4000, 4001, 4002);
    put_face(4000, 4002, 4003);
    put_read(4000);
    repeat (10) put_face(4000, 4002, 4001);
    put_read(4000);
    put_read(4001);

    drain();
    repeat (150) @(posedge clk);

    $display("Covered %0d requests: %0d writes, %0d faces, %0d reads, %0d clears,",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("under three stall mixes, plus a %0d-face run into accumulator saturation.",
             BURST_FACES);
    if (mismatch_count == 0 && normals_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatch_count, normals_pending);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
